@@ rtl/deq_pkg.sv @@
// Shared codes, widths and types for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int DEFAULT_CAPACITY  = 1024;
    localparam int DEFAULT_WORD_BITS = 32;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PEEK_BACK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_COUNT      = 3'd6;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic exec;   // take the item: update indices, write or read the ring
        logic load;   // move the finished result into the output register
    } deq_cmd_t;

endpackage

`default_nettype wire

@@ rtl/deq_ram.sv @@
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        // hold the read data between accesses
        if (en) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/deq_ctrl.sv @@
// Controller: accepts one item, waits for the ring read, hands the result off.
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output deq_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RESP = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                cmd.exec = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                // hold the result until the output register is free
                if (!out_valid_reg || m_tready) begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

`ifndef ASSERT_OFF
    a_exec_to_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> state_reg == ST_RESP)
        else $error("accepted item did not move to response state");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> m_tvalid)
        else $error("loaded result not presented");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while still waiting");
`endif

endmodule

`default_nettype wire

@@ rtl/deq_dp.sv @@
// Datapath: front index, count, ring RAM and the result register.
`timescale 1ns / 1ps
`default_nettype none

module deq_dp
    import deq_pkg::*;
#(
    parameter int CAPACITY  = DEFAULT_CAPACITY,
    parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire deq_cmd_t             cmd,
    input  wire logic [MODE_W-1:0]    in_mode,
    input  wire logic signed [VALUE_W-1:0] in_value,
    output logic signed [VALUE_W-1:0] out_value,
    output logic [STATUS_W-1:0]       out_status,
    output logic [COUNT_W-1:0]        out_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [IDX_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                hit_reg, hit_next;

    logic signed [VALUE_W-1:0] out_value_reg;
    logic [STATUS_W-1:0]       out_status_reg;
    logic [COUNT_W-1:0]        out_count_reg;

    logic             full, empty, is_push, is_access, at_front;
    logic [IDX_W-1:0] front_inc, front_dec, tail_idx, back_idx, ram_addr;
    logic [SUM_W-1:0] sum, sum_m1;
    logic             ram_we;
    logic [WORD_BITS-1:0] ram_rdata;

    always_comb begin
        full      = (count_reg == CNT_W'(CAPACITY));
        empty     = (count_reg == '0);
        is_push   = (in_mode inside {MODE_PUSH_BACK, MODE_PUSH_FRONT});
        is_access = (in_mode inside {MODE_PEEK_FRONT, MODE_PEEK_BACK,
                                     MODE_POP_FRONT, MODE_POP_BACK});
        at_front  = (in_mode inside {MODE_PEEK_FRONT, MODE_POP_FRONT});

        front_inc = (front_reg == IDX_W'(CAPACITY - 1)) ? '0 : front_reg + 1'b1;
        front_dec = (front_reg == '0) ? IDX_W'(CAPACITY - 1) : front_reg - 1'b1;

        // ring positions: one compare and subtract, sums stay below 2*CAPACITY
        sum    = SUM_W'(front_reg) + SUM_W'(count_reg);
        sum_m1 = sum - 1'b1;
        tail_idx = (sum >= SUM_W'(CAPACITY)) ? IDX_W'(sum - SUM_W'(CAPACITY))
                                             : IDX_W'(sum);
        back_idx = (sum_m1 >= SUM_W'(CAPACITY)) ? IDX_W'(sum_m1 - SUM_W'(CAPACITY))
                                                : IDX_W'(sum_m1);

        case (in_mode)
            MODE_PUSH_BACK:  ram_addr = tail_idx;
            MODE_PUSH_FRONT: ram_addr = front_dec;
            default:         ram_addr = at_front ? front_reg : back_idx;
        endcase

        ram_we = cmd.exec && is_push && !full;

        front_next  = front_reg;
        count_next  = count_reg;
        status_next = status_reg;
        hit_next    = hit_reg;
        if (cmd.exec) begin
            status_next = STATUS_OK;
            hit_next    = is_access && !empty;
            if (is_push && full) begin
                status_next = STATUS_FULL;
            end else if (is_access && empty) begin
                status_next = STATUS_EMPTY;
            end else begin
                case (in_mode)
                    MODE_PUSH_BACK: begin
                        count_next = count_reg + 1'b1;
                    end
                    MODE_PUSH_FRONT: begin
                        front_next = front_dec;
                        count_next = count_reg + 1'b1;
                    end
                    MODE_POP_FRONT: begin
                        front_next = front_inc;
                        count_next = count_reg - 1'b1;
                    end
                    MODE_POP_BACK: begin
                        count_next = count_reg - 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    deq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_ring (
        .aclk  (aclk),
        .en    (cmd.exec),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (WORD_BITS'($unsigned(in_value))),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
        end else begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        hit_reg    <= hit_next;
        if (cmd.load) begin
            out_value_reg  <= hit_reg ? VALUE_W'($signed(ram_rdata)) : '0;
            out_status_reg <= status_reg;
            out_count_reg  <= COUNT_W'(count_reg);
        end
    end

    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_front_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        SUM_W'(front_reg) < SUM_W'(CAPACITY))
        else $error("front index outside the ring");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && is_push && full) |=> (count_reg == $past(count_reg)
            && front_reg == $past(front_reg) && status_reg == STATUS_FULL))
        else $error("push on a full queue changed state");
`endif

endmodule

`default_nettype wire

@@ rtl/double_ended_queue_top.sv @@
// Top level of the double-ended queue: controller, datapath and port packing.
//
// Bounded deque of signed words kept in a ring buffer (one RAM, front index
// and count). Each input item on s_* carries one operation in s_tuser
// (push back, push front, peek front, peek back, pop front, pop back, count)
// and the word to push in s_tdata. Each item gives exactly one result on m_*:
// the peeked or popped word, the status (ok, empty, full and dropped) and
// the number of stored words after the operation.
// For each item, the accept cycle updates the indices and starts the ring
// access; in the response state the registered RAM read data is loaded into
// the result register once that register is free. A new item is not accepted
// until the previous item has loaded its result.
// The result register lets the next item be accepted while a result waits;
// if m_tready stays low the block holds that item's result internally and
// stops accepting until the output register frees up.
// Reset (aresetn low, synchronous) empties the queue at once; the RAM
// contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_top
    import deq_pkg::*;
#(
    parameter int CAPACITY  = DEFAULT_CAPACITY,
    parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] push_value
    input  wire logic [2:0]  s_tuser,   // [2:0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [31:0] read_value, [42:32] entry_count
    output logic [1:0]       m_tuser    // [1:0] status
);

    deq_cmd_t                  cmd;
    logic signed [VALUE_W-1:0] out_value;
    logic [STATUS_W-1:0]       out_status;
    logic [COUNT_W-1:0]        out_count;

    deq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    deq_dp #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_mode    (s_tuser),
        .in_value   ($signed(s_tdata)),
        .out_value  (out_value),
        .out_status (out_status),
        .out_count  (out_count)
    );

    assign m_tdata = {5'd0, out_count, out_value};
    assign m_tuser = out_status;

endmodule

`default_nettype wire

@@ bench/double_ended_queue_top_tb.sv @@
// Self-checking testbench for the double-ended queue: directed, fill and random traffic.
`timescale 1ns / 1ps

module double_ended_queue_top_tb;
    import deq_pkg::*;

    localparam int DEPTH = DEFAULT_CAPACITY;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef logic [MODE_W-1:0] MODE_T;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
    } deq_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    // predicted deque contents and indices
    logic [VALUE_W-1:0] ring_words [DEPTH];
    logic [9:0]         head_slot = '0;
    logic [COUNT_W-1:0] word_count = '0;

    deq_result_t pending_results [$];
    deq_result_t oldest;
    int          error_count = 0;
    int          cycle_count = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;

    double_ended_queue_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Apply one operation to the predicted deque and return its result.
    function automatic deq_result_t deque_apply(logic [MODE_W-1:0] op,
                                                logic [VALUE_W-1:0] word);
        deq_result_t r;
        logic [9:0]  slot;
        r = '0;
        case (op)
            MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
                if (word_count >= DEPTH) begin
                    r.status = STATUS_FULL;
                end else if (op == MODE_PUSH_BACK) begin
                    slot = head_slot + word_count[9:0];
                    ring_words[slot] = word;
                    word_count = word_count + 1'b1;
                end else begin
                    head_slot = head_slot - 1'b1;
                    ring_words[head_slot] = word;
                    word_count = word_count + 1'b1;
                end
            end
            MODE_PEEK_FRONT, MODE_PEEK_BACK, MODE_POP_FRONT, MODE_POP_BACK: begin
                if (word_count == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    if (op == MODE_PEEK_FRONT || op == MODE_POP_FRONT)
                        slot = head_slot;
                    else
                        slot = head_slot + word_count[9:0] - 1'b1;
                    r.read_value = ring_words[slot];
                    if (op == MODE_POP_FRONT) begin
                        head_slot = head_slot + 1'b1;
                        word_count = word_count - 1'b1;
                    end else if (op == MODE_POP_BACK) begin
                        word_count = word_count - 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = word_count;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what,
                 got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending", m_tdata[31:0], '0);
            end else begin
                oldest = pending_results[0];
                pending_results.delete(0);
                if (m_tdata[31:0] !== oldest.read_value)
                    report_mismatch("read_value", m_tdata[31:0], oldest.read_value);
                if (m_tuser !== oldest.status)
                    report_mismatch("status", 32'(m_tuser), 32'(oldest.status));
                if (m_tdata[42:32] !== oldest.entry_count)
                    report_mismatch("entry_count", 32'(m_tdata[42:32]),
                                    32'(oldest.entry_count));
                if (m_tdata[47:43] !== 5'd0)
                    report_mismatch("tdata pad", 32'(m_tdata[47:43]), '0);
            end
        end
    end

    // Offer one item, hold it until accepted, then record its expected result.
    task automatic send_op(logic [MODE_W-1:0] op, logic [VALUE_W-1:0] word);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        pending_results.insert(pending_results.size(), deque_apply(op, word));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [VALUE_W-1:0] rand_word();
        case ($urandom_range(19))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_and_extremes();
        send_op(MODE_PEEK_FRONT, 32'h1234_5678);
        send_op(MODE_PEEK_BACK, 32'hffff_ffff);
        send_op(MODE_POP_FRONT, '0);
        send_op(MODE_POP_BACK, '0);
        send_op(MODE_COUNT, '0);
        send_op(MODE_UNUSED, 32'hffff_ffff);
        send_op(MODE_PUSH_BACK, 32'h7fff_ffff);
        send_op(MODE_PUSH_FRONT, 32'h8000_0000);
        send_op(MODE_PUSH_BACK, 32'hffff_ffff);
        send_op(MODE_PUSH_FRONT, 32'h0000_0000);
        send_op(MODE_PEEK_FRONT, '0);
        send_op(MODE_PEEK_BACK, '0);
        send_op(MODE_COUNT, 32'h5555_aaaa);
        send_op(MODE_UNUSED, '0);
        send_op(MODE_POP_BACK, '0);
        send_op(MODE_POP_FRONT, '0);
        send_op(MODE_POP_FRONT, '0);
        send_op(MODE_PEEK_BACK, '0);
        send_op(MODE_POP_BACK, '0);
        send_op(MODE_POP_BACK, '0);
        send_op(MODE_PEEK_FRONT, '0);
        wait_drained();
    endtask

    // Fill to capacity from both ends, push into the full deque, then drain it.
    task automatic test_fill_to_capacity();
        sender_idle_pct    = 0;
        receiver_stall_pct = 28;
        while (word_count < DEPTH)
            send_op($urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, rand_word());
        send_op(MODE_PUSH_BACK, 32'hdead_beef);
        send_op(MODE_PUSH_FRONT, 32'h8000_0000);
        send_op(MODE_PEEK_FRONT, '0);
        send_op(MODE_PEEK_BACK, '0);
        send_op(MODE_COUNT, '0);
        while (word_count != 0) begin
            case ($urandom_range(3))
                0: send_op(MODE_POP_FRONT, rand_word());
                1: send_op(MODE_POP_BACK, rand_word());
                2: send_op(MODE_PEEK_BACK, rand_word());
                default: send_op(MODE_POP_FRONT, rand_word());
            endcase
        end
        send_op(MODE_POP_BACK, '0);
        wait_drained();
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items,
                                       bit hold_off);
        int push_pct;
        int pick;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++) begin
            // alternate growing and shrinking stretches so empty is hit often
            push_pct = ((i / 40) % 2 == 0) ? 60 : 20;
            pick = $urandom_range(99);
            if (hold_off && i == n_items / 2)
                wait_drained();
            if (pick < push_pct)
                send_op($urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, rand_word());
            else if (pick < 92)
                send_op(MODE_T'($urandom_range(MODE_POP_BACK, MODE_PEEK_FRONT)),
                        rand_word());
            else
                send_op($urandom_range(1) ? MODE_COUNT : MODE_UNUSED, rand_word());
        end
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_and_extremes();
        test_fill_to_capacity();
        test_random_traffic(0, 0, 225, 1'b0);
        test_random_traffic(79, 0, 225, 1'b1);
        test_random_traffic(0, 79, 225, 1'b0);
        test_random_traffic(28, 28, 225, 1'b0);
        receiver_stall_pct = 0;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
